@@ design/pl0_pkg.sv @@
// pl0 p-machine execute unit: shared constants and codes
// no dependencies; imported by pl0_stack_machine_execute
`timescale 1ns / 1ps
`default_nettype none

package pl0_pkg;

	localparam int STACK_DEPTH = 2048;
	localparam int CODE_DEPTH  = 4096;
	localparam int SAW         = $clog2(STACK_DEPTH);   // stack address width
	localparam int TCW         = SAW + 1;               // fill count width, 0..STACK_DEPTH
	localparam int PCW         = $clog2(CODE_DEPTH);
	localparam int WORD        = 32;
	localparam int DCW         = $clog2(WORD);           // divider step counter

	typedef enum logic [3:0] {
		MODE_LIT = 4'd1,
		MODE_OPR = 4'd2,
		MODE_LOD = 4'd3,
		MODE_STO = 4'd4,
		MODE_CAL = 4'd5,
		MODE_INC = 4'd6,
		MODE_JMP = 4'd7,
		MODE_JPC = 4'd8,
		MODE_OUT = 4'd9,
		MODE_IN  = 4'd10
	} mode_t;

	typedef enum logic [3:0] {
		OPR_RET = 4'd0,
		OPR_NEG = 4'd1,
		OPR_ADD = 4'd2,
		OPR_SUB = 4'd3,
		OPR_MUL = 4'd4,
		OPR_DIV = 4'd5,
		OPR_ODD = 4'd6,
		OPR_MOD = 4'd7,
		OPR_EQL = 4'd8,
		OPR_NEQ = 4'd9,
		OPR_LSS = 4'd10,
		OPR_LEQ = 4'd11,
		OPR_GTR = 4'd12,
		OPR_GEQ = 4'd13
	} opr_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DIVZ  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ design/pl0_stack_machine_execute.sv @@
// pl0 p-machine execute unit: sequencer, data stack memory, shared alu and divider
// depends on pl0_pkg
`timescale 1ns / 1ps
`default_nettype none

// Executes one fetched PL/0 instruction per input beat and returns one result beat
// (next pc, OUT value, halt flag, status). The data stack is a single-port-write,
// single-port-read memory with registered read data; every stack read passes through
// an address, a wait and a use step. After reset the block sweeps all STACK_DEPTH
// (2048) stack words to zero, one word per cycle, before in_ready first rises.
// DIV and MOD run the one-bit-per-cycle divider, which a zero divisor skips; LOD,
// STO and CAL first walk one static link per level (up to 15), each link a memory
// read. Once halted, an instruction is answered without being executed. A stack
// fault ends an instruction early.
// A finished result sits in an output register, so the next instruction may be
// accepted while it waits; the result of that instruction waits until the first
// result beat is taken.
module pl0_stack_machine_execute (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [3:0]                mode,
	input  wire logic [3:0]                level,
	input  wire logic signed [31:0]        operand,
	input  wire logic signed [31:0]        in_value,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output logic [pl0_pkg::PCW-1:0]        next_pc,
	output logic                           out_valid,
	output logic signed [31:0]             out_value,
	output logic                           halted,
	output logic [1:0]                     status
);
	import pl0_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_START, S_WAIT, S_WALK, S_WALKRD, S_ACC, S_LODRD, S_STORD,
		S_CAL2, S_CAL3, S_RET1, S_RET2, S_UNARY, S_BIN1, S_BIN2, S_DIV, S_DIVEND,
		S_POP, S_DONE
	} state_t;

	// stack memory
	logic [WORD-1:0] mem [STACK_DEPTH];
	logic            mem_we_q;
	logic [SAW-1:0]  mem_wa_q;
	logic [WORD-1:0] mem_wd_q;
	logic [SAW-1:0]  mem_ra_q;
	logic [WORD-1:0] rd_q;

	// sequencer and machine state
	state_t          state_q;
	state_t          ret_q;
	logic [SAW-1:0]  clr_q;
	logic [PCW-1:0]  pc_q;
	logic [SAW-1:0]  bp_q;
	logic [TCW-1:0]  tc_q;        // top_ptr + 1
	logic            halt_q;

	// latched instruction
	logic [3:0]      mode_q;
	logic [3:0]      level_q;
	logic [WORD-1:0] op_q;
	logic [WORD-1:0] inval_q;

	// working registers
	logic [SAW-1:0]  cur_q;
	logic [3:0]      lvl_q;
	logic [SAW-1:0]  ea_q;
	logic [WORD-1:0] a_q;
	logic [WORD-1:0] b_q;
	logic [WORD-1:0] rem_q;
	logic [WORD-1:0] quo_q;
	logic [DCW-1:0]  dcnt_q;
	logic [1:0]      st_q;
	logic            ov_q;
	logic [WORD-1:0] oval_q;

	// result register
	logic            res_v_q;
	logic [PCW-1:0]  res_pc_q;
	logic            res_ov_q;
	logic [WORD-1:0] res_oval_q;
	logic            res_halt_q;
	logic [1:0]      res_st_q;

	// combinational helpers
	logic [TCW-1:0]  tc_dec;
	logic [TCW-1:0]  tc_dec2;
	logic [TCW-1:0]  tc_inc;
	logic [3:0]      func;
	logic            opr_hi_zero;
	logic [WORD+1:0] inc_sum;
	logic [WORD+1:0] ea_sum;
	logic            inc_ok;
	logic            ea_ok;
	logic [WORD-1:0] alu_res;
	logic [WORD-1:0] mag_b;
	logic [WORD:0]   dv_t;
	logic [WORD:0]   dv_d;
	logic            dv_ge;
	logic [WORD:0]   dv_sub;
	logic [WORD-1:0] div_res;

	function automatic logic [WORD-1:0] mag(input logic [WORD-1:0] x);
		mag = x[WORD-1] ? (~x + WORD'(1)) : x;
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we_q) begin
			mem[mem_wa_q] <= mem_wd_q;
		end
		rd_q <= mem[mem_ra_q];
	end

	assign tc_dec      = tc_q - TCW'(1);
	assign tc_dec2     = tc_q - TCW'(2);
	assign tc_inc      = tc_q + TCW'(1);
	assign func        = op_q[3:0];
	assign opr_hi_zero = (op_q[WORD-1:4] == '0);

	// INC: new fill count must land in 0..STACK_DEPTH
	assign inc_sum = {{(WORD+2-TCW){1'b0}}, tc_q} + {{2{op_q[WORD-1]}}, op_q};
	assign inc_ok  = !inc_sum[WORD+1] && (inc_sum <= (WORD+2)'(STACK_DEPTH));
	// LOD / STO effective address, base from the link walk
	assign ea_sum  = {{(WORD+2-SAW){1'b0}}, cur_q} + {{2{op_q[WORD-1]}}, op_q};
	assign ea_ok   = !ea_sum[WORD+1] && (ea_sum < (WORD+2)'(STACK_DEPTH));

	// shared alu: a from the read port, b held
	always_comb begin
		case (func)
			OPR_ADD: alu_res = rd_q + b_q;
			OPR_SUB: alu_res = rd_q - b_q;
			OPR_MUL: alu_res = rd_q * b_q;
			OPR_EQL: alu_res = WORD'(rd_q == b_q);
			OPR_NEQ: alu_res = WORD'(rd_q != b_q);
			OPR_LSS: alu_res = WORD'($signed(rd_q) < $signed(b_q));
			OPR_LEQ: alu_res = WORD'(!($signed(b_q) < $signed(rd_q)));
			OPR_GTR: alu_res = WORD'($signed(b_q) < $signed(rd_q));
			default: alu_res = WORD'(!($signed(rd_q) < $signed(b_q)));
		endcase
	end

	// restoring divider step on magnitudes
	assign mag_b  = mag(b_q);
	assign dv_t   = {rem_q, quo_q[WORD-1]};
	assign dv_d   = {1'b0, mag_b};
	assign dv_ge  = (dv_t >= dv_d);
	assign dv_sub = dv_ge ? (dv_t - dv_d) : dv_t;

	always_comb begin
		if (func == OPR_DIV) begin
			div_res = (a_q[WORD-1] ^ b_q[WORD-1]) ? (~quo_q + WORD'(1)) : quo_q;
		end else begin
			div_res = a_q[WORD-1] ? (~rem_q + WORD'(1)) : rem_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = res_v_q;
	assign next_pc   = res_pc_q;
	assign out_valid = res_ov_q;
	assign out_value = res_oval_q;
	assign halted    = res_halt_q;
	assign status    = res_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= S_IDLE;
			clr_q      <= '0;
			pc_q       <= '0;
			bp_q       <= '0;
			tc_q       <= '0;
			halt_q     <= 1'b0;
			mem_we_q   <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			mem_we_q <= 1'b0;
			// done reloads the result register itself
			if (res_v_q && res_ready && state_q != S_DONE) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= clr_q;
					mem_wd_q <= '0;
					clr_q    <= clr_q + SAW'(1);
					if (clr_q == SAW'(STACK_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						level_q <= level;
						op_q    <= operand;
						inval_q <= in_value;
						st_q    <= ST_OK;
						ov_q    <= 1'b0;
						oval_q  <= '0;
						if (halt_q) begin
							state_q <= S_DONE;
						end else begin
							pc_q    <= pc_q + PCW'(1);
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_DONE;
					case (mode_q)
						MODE_LIT, MODE_IN: begin
							if (tc_q < TCW'(STACK_DEPTH)) begin
								mem_we_q <= 1'b1;
								mem_wa_q <= tc_q[SAW-1:0];
								mem_wd_q <= (mode_q == MODE_LIT) ? op_q : inval_q;
								tc_q     <= tc_inc;
							end else begin
								st_q <= ST_RANGE;
							end
						end
						MODE_OPR: begin
							if (opr_hi_zero && func == OPR_RET) begin
								if (bp_q <= SAW'(STACK_DEPTH - 4)) begin
									mem_ra_q <= bp_q + SAW'(2);
									ret_q    <= S_RET1;
									state_q  <= S_WAIT;
								end else begin
									st_q <= ST_RANGE;
								end
							end else if (opr_hi_zero && (func == OPR_NEG || func == OPR_ODD)) begin
								if (tc_q != '0) begin
									mem_ra_q <= tc_dec[SAW-1:0];
									ret_q    <= S_UNARY;
									state_q  <= S_WAIT;
								end else begin
									st_q <= ST_RANGE;
								end
							end else if (opr_hi_zero && func >= OPR_ADD && func <= OPR_GEQ) begin
								if (tc_q >= TCW'(2)) begin
									mem_ra_q <= tc_dec[SAW-1:0];
									ret_q    <= S_BIN1;
									state_q  <= S_WAIT;
								end else begin
									st_q <= ST_RANGE;
								end
							end
						end
						MODE_LOD, MODE_STO, MODE_CAL: begin
							cur_q   <= bp_q;
							lvl_q   <= level_q;
							state_q <= S_WALK;
						end
						MODE_INC: begin
							if (inc_ok) begin
								tc_q <= inc_sum[TCW-1:0];
							end else begin
								st_q <= ST_RANGE;
							end
						end
						MODE_JMP: begin
							pc_q <= op_q[PCW-1:0];
						end
						MODE_JPC, MODE_OUT: begin
							if (tc_q != '0) begin
								mem_ra_q <= tc_dec[SAW-1:0];
								ret_q    <= S_POP;
								state_q  <= S_WAIT;
							end else begin
								st_q <= ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
				S_WAIT: begin
					// read data lands in rd_q at the end of this cycle
					state_q <= ret_q;
				end
				S_WALK: begin
					if (lvl_q == '0) begin
						state_q <= S_ACC;
					end else if (cur_q != SAW'(STACK_DEPTH - 1)) begin
						mem_ra_q <= cur_q + SAW'(1);
						ret_q    <= S_WALKRD;
						state_q  <= S_WAIT;
					end else begin
						st_q    <= ST_RANGE;
						state_q <= S_DONE;
					end
				end
				S_WALKRD: begin
					if (rd_q < WORD'(STACK_DEPTH)) begin
						cur_q   <= rd_q[SAW-1:0];
						lvl_q   <= lvl_q - 4'd1;
						state_q <= S_WALK;
					end else begin
						st_q    <= ST_RANGE;
						state_q <= S_DONE;
					end
				end
				S_ACC: begin
					state_q <= S_DONE;
					case (mode_q)
						MODE_LOD: begin
							if (ea_ok && tc_q < TCW'(STACK_DEPTH)) begin
								mem_ra_q <= ea_sum[SAW-1:0];
								ret_q    <= S_LODRD;
								state_q  <= S_WAIT;
							end else begin
								st_q <= ST_RANGE;
							end
						end
						MODE_STO: begin
							if (ea_ok && tc_q != '0) begin
								mem_ra_q <= tc_dec[SAW-1:0];
								ea_q     <= ea_sum[SAW-1:0];
								ret_q    <= S_STORD;
								state_q  <= S_WAIT;
							end else begin
								st_q <= ST_RANGE;
							end
						end
						default: begin
							// call frame: static link, dynamic link, return pc
							if (tc_q <= TCW'(STACK_DEPTH - 4)) begin
								mem_we_q <= 1'b1;
								mem_wa_q <= tc_q[SAW-1:0] + SAW'(1);
								mem_wd_q <= WORD'(cur_q);
								state_q  <= S_CAL2;
							end else begin
								st_q <= ST_RANGE;
							end
						end
					endcase
				end
				S_LODRD: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= tc_q[SAW-1:0];
					mem_wd_q <= rd_q;
					tc_q     <= tc_inc;
					state_q  <= S_DONE;
				end
				S_STORD: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= ea_q;
					mem_wd_q <= rd_q;
					tc_q     <= tc_dec;
					state_q  <= S_DONE;
				end
				S_CAL2: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= tc_q[SAW-1:0] + SAW'(2);
					mem_wd_q <= WORD'(bp_q);
					state_q  <= S_CAL3;
				end
				S_CAL3: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= tc_q[SAW-1:0] + SAW'(3);
					mem_wd_q <= WORD'(pc_q);
					bp_q     <= tc_q[SAW-1:0];
					pc_q     <= op_q[PCW-1:0];
					state_q  <= S_DONE;
				end
				S_RET1: begin
					if (rd_q < WORD'(STACK_DEPTH)) begin
						a_q      <= rd_q;
						mem_ra_q <= bp_q + SAW'(3);
						ret_q    <= S_RET2;
						state_q  <= S_WAIT;
					end else begin
						st_q    <= ST_RANGE;
						state_q <= S_DONE;
					end
				end
				S_RET2: begin
					pc_q <= rd_q[PCW-1:0];
					bp_q <= a_q[SAW-1:0];
					tc_q <= TCW'(bp_q);
					if (bp_q == '0) begin
						halt_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_UNARY: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= tc_dec[SAW-1:0];
					mem_wd_q <= (func == OPR_NEG) ? (~rd_q + WORD'(1)) : WORD'(rd_q[0]);
					state_q  <= S_DONE;
				end
				S_BIN1: begin
					b_q      <= rd_q;
					mem_ra_q <= tc_dec2[SAW-1:0];
					ret_q    <= S_BIN2;
					state_q  <= S_WAIT;
				end
				S_BIN2: begin
					a_q <= rd_q;
					if (func == OPR_DIV || func == OPR_MOD) begin
						if (b_q == '0) begin
							mem_we_q <= 1'b1;
							mem_wa_q <= tc_dec2[SAW-1:0];
							mem_wd_q <= '0;
							tc_q     <= tc_dec;
							st_q     <= ST_DIVZ;
							state_q  <= S_DONE;
						end else begin
							rem_q   <= '0;
							quo_q   <= mag(rd_q);
							dcnt_q  <= '0;
							state_q <= S_DIV;
						end
					end else begin
						mem_we_q <= 1'b1;
						mem_wa_q <= tc_dec2[SAW-1:0];
						mem_wd_q <= alu_res;
						tc_q     <= tc_dec;
						state_q  <= S_DONE;
					end
				end
				S_DIV: begin
					rem_q  <= dv_sub[WORD-1:0];
					quo_q  <= {quo_q[WORD-2:0], dv_ge};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(WORD - 1)) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					mem_we_q <= 1'b1;
					mem_wa_q <= tc_dec2[SAW-1:0];
					mem_wd_q <= div_res;
					tc_q     <= tc_dec;
					state_q  <= S_DONE;
				end
				S_POP: begin
					if (mode_q == MODE_JPC) begin
						if (rd_q == '0) begin
							pc_q <= op_q[PCW-1:0];
						end
					end else begin
						ov_q   <= 1'b1;
						oval_q <= rd_q;
					end
					tc_q    <= tc_dec;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_v_q || res_ready) begin
						res_v_q    <= 1'b1;
						res_pc_q   <= pc_q;
						res_ov_q   <= ov_q;
						res_oval_q <= oval_q;
						res_halt_q <= halt_q;
						res_st_q   <= st_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// fill count never passes the stack size
	a_tc_range: assert property (@(posedge clk) disable iff (!arst_n)
		tc_q <= TCW'(STACK_DEPTH))
		else $error("stack fill count out of range");

	// all stack writes of an item are done before the next one starts
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |-> !mem_we_q)
		else $error("stack write pending at instruction start");

	// a halted result carries no output and a clean status
	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && res_halt_q) |-> (!res_ov_q && res_st_q == ST_OK))
		else $error("halted result with output or fault");

	// an OUT beat only comes from a good pop
	a_out_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && res_ov_q) |-> (res_st_q == ST_OK))
		else $error("output value with fault status");
`endif

endmodule

`default_nettype wire

@@ tb/pl0_stack_machine_execute_tb.sv @@
// testbench for pl0_stack_machine_execute: directed and random instruction streams,
// checked beat by beat against a behavioral p-machine kept in the bench
// depends on pl0_pkg and design/pl0_stack_machine_execute.sv
`timescale 1ns / 1ps

module pl0_stack_machine_execute_tb;
	import pl0_pkg::*;

	localparam longint CYCLE_LIMIT = 1_500_000;
	localparam int     RAND_ITEMS  = 1200;

	typedef struct packed {
		logic [PCW-1:0] pc;
		logic           ov;
		logic [31:0]    oval;
		logic           halt;
		logic [1:0]     st;
	} pmach_res_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         mode;
	logic [3:0]         level;
	logic signed [31:0] operand;
	logic signed [31:0] in_value;
	logic               res_valid;
	logic               res_ready;
	logic [PCW-1:0]     next_pc;
	logic               out_valid;
	logic signed [31:0] out_value;
	logic               halted;
	logic [1:0]         status;

	// shadow p-machine state
	logic [31:0]    mach_stack [STACK_DEPTH];
	logic [PCW-1:0] mach_pc;
	longint         mach_bp;
	longint         mach_sp;
	logic           mach_halt;

	pmach_res_t expected_q [$];
	int         mismatch_cnt;
	int         beats_sent;
	int         beats_checked;
	int         out_beats;
	int         fault_beats;
	longint     cycle_cnt;
	bit         idle_on;

	pl0_stack_machine_execute i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.level     (level),
		.operand   (operand),
		.in_value  (in_value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.next_pc   (next_pc),
		.out_valid (out_valid),
		.out_value (out_value),
		.halted    (halted),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stack index check
	function automatic bit in_range(input longint idx);
		return idx >= 0 && idx < STACK_DEPTH;
	endfunction

	// follow static links down lev frames; 0 on a link outside the stack
	function automatic bit walk_static(input int lev, inout longint b);
		longint cur;
		cur = b;
		for (int i = 0; i < lev; i++) begin
			if (!in_range(cur + 1) || mach_stack[cur + 1] >= STACK_DEPTH)
				return 1'b0;
			cur = longint'(mach_stack[cur + 1]);
		end
		b = cur;
		return 1'b1;
	endfunction

	function automatic logic [31:0] magnitude(input logic [31:0] x);
		return x[31] ? -x : x;
	endfunction

	// two-operand opr group; dz set on divide or modulo by zero
	function automatic logic [31:0] alu_binop(input logic [3:0] f, input logic [31:0] a,
			input logic [31:0] b, output bit dz);
		logic [31:0] q;
		dz = 1'b0;
		case (f)
			OPR_ADD: return a + b;
			OPR_SUB: return a - b;
			OPR_MUL: return a * b;
			OPR_DIV: begin
				if (b == 0) begin
					dz = 1'b1;
					return 0;
				end
				q = magnitude(a) / magnitude(b);
				return (a[31] ^ b[31]) ? -q : q;
			end
			OPR_MOD: begin
				if (b == 0) begin
					dz = 1'b1;
					return 0;
				end
				q = magnitude(a) % magnitude(b);
				return a[31] ? -q : q;
			end
			OPR_EQL: return {31'd0, a == b};
			OPR_NEQ: return {31'd0, a != b};
			OPR_LSS: return {31'd0, $signed(a) < $signed(b)};
			OPR_LEQ: return {31'd0, $signed(a) <= $signed(b)};
			OPR_GTR: return {31'd0, $signed(a) > $signed(b)};
			default: return {31'd0, $signed(a) >= $signed(b)};
		endcase
	endfunction

	// execute one instruction on the shadow machine
	task automatic execute_instr(input logic [3:0] md, input logic [3:0] lv,
			input logic [31:0] m, input logic [31:0] iv, output pmach_res_t r);
		longint sp, bp, b, ns, ms;
		logic [PCW-1:0] pc;
		bit bad, dz;
		r = '0;
		if (mach_halt) begin
			r.pc   = mach_pc;
			r.halt = 1'b1;
			return;
		end
		sp  = mach_sp;
		bp  = mach_bp;
		ms  = longint'($signed(m));
		pc  = mach_pc + 1'b1;
		bad = 1'b0;
		dz  = 1'b0;
		case (md)
			MODE_LIT, MODE_IN: begin
				if (!in_range(sp + 1)) bad = 1'b1;
				else begin
					sp++;
					mach_stack[sp] = (md == MODE_IN) ? iv : m;
				end
			end
			MODE_OPR: begin
				if (m == OPR_RET) begin
					if (!in_range(bp + 3) || mach_stack[bp + 2] >= STACK_DEPTH) bad = 1'b1;
					else begin
						sp = bp - 1;
						pc = mach_stack[bp + 3][PCW-1:0];
						bp = longint'(mach_stack[bp + 2]);
						if (sp == -1) mach_halt = 1'b1;
					end
				end else if (m == OPR_NEG || m == OPR_ODD) begin
					if (!in_range(sp)) bad = 1'b1;
					else if (m == OPR_NEG) mach_stack[sp] = -mach_stack[sp];
					else mach_stack[sp] = mach_stack[sp] & 32'd1;
				end else if (m <= OPR_GEQ) begin
					if (sp < 1 || !in_range(sp)) bad = 1'b1;
					else begin
						mach_stack[sp - 1] = alu_binop(m[3:0], mach_stack[sp - 1],
							mach_stack[sp], dz);
						sp--;
					end
				end
			end
			MODE_LOD: begin
				b = bp;
				if (!walk_static(int'(lv), b) || !in_range(b + ms) || !in_range(sp + 1))
					bad = 1'b1;
				else begin
					sp++;
					mach_stack[sp] = mach_stack[b + ms];
				end
			end
			MODE_STO: begin
				b = bp;
				if (!walk_static(int'(lv), b) || !in_range(b + ms) || !in_range(sp))
					bad = 1'b1;
				else begin
					mach_stack[b + ms] = mach_stack[sp];
					sp--;
				end
			end
			MODE_CAL: begin
				b = bp;
				if (!walk_static(int'(lv), b) || !in_range(sp + 2) || !in_range(sp + 4))
					bad = 1'b1;
				else begin
					mach_stack[sp + 2] = 32'(b);
					mach_stack[sp + 3] = 32'(bp);
					mach_stack[sp + 4] = 32'(pc);
					bp = sp + 1;
					pc = m[PCW-1:0];
				end
			end
			MODE_INC: begin
				ns = sp + ms;
				if (ns < -1 || ns >= STACK_DEPTH) bad = 1'b1;
				else sp = ns;
			end
			MODE_JMP: pc = m[PCW-1:0];
			MODE_JPC: begin
				if (!in_range(sp)) bad = 1'b1;
				else begin
					if (mach_stack[sp] == 0) pc = m[PCW-1:0];
					sp--;
				end
			end
			MODE_OUT: begin
				if (!in_range(sp)) bad = 1'b1;
				else begin
					r.ov   = 1'b1;
					r.oval = mach_stack[sp];
					sp--;
				end
			end
			default: ;
		endcase
		if (bad) begin
			r.st = ST_RANGE;
			sp   = mach_sp;
			bp   = mach_bp;
		end else if (dz) r.st = ST_DIVZ;
		else r.st = ST_OK;
		mach_pc = pc;
		mach_sp = sp;
		mach_bp = bp;
		r.pc    = pc;
		r.halt  = mach_halt;
	endtask

	// drive one instruction beat, predict its result on acceptance
	task automatic send_instr(input logic [3:0] md, input logic [3:0] lv,
			input logic [31:0] m, input logic [31:0] iv);
		pmach_res_t r;
		in_valid <= 1'b1;
		mode     <= md;
		level    <= lv;
		operand  <= m;
		in_value <= iv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		execute_instr(md, lv, m, iv, r);
		expected_q.push_back(r);
		beats_sent++;
		if (idle_on && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// result side: compare the accepted beat, then choose the next ready
	always @(posedge clk) begin
		pmach_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("result beat with nothing expected: pc=%0d st=%0d",
						next_pc, status);
			end else begin
				want = expected_q.pop_front();
				beats_checked++;
				if (out_valid) out_beats++;
				if (status != ST_OK) fault_beats++;
				if (next_pc !== want.pc || out_valid !== want.ov ||
						out_value !== want.oval || halted !== want.halt ||
						status !== want.st) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("beat %0d mismatch: exp pc=%0d ov=%0b val=%h halt=%0b st=%0d",
							beats_checked, want.pc, want.ov, want.oval, want.halt, want.st);
						$display("  got pc=%0d ov=%0b val=%h halt=%0b st=%0d",
							next_pc, out_valid, out_value, halted, status);
					end
				end
			end
		end
		res_ready <= !idle_on || $urandom_range(0, 99) >= 11;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// arithmetic extremes, mod by zero, odd on a negative value
	task automatic test_arith();
		send_instr(MODE_LIT, 4'd0, 32'h7fff_ffff, $urandom);
		send_instr(MODE_LIT, 4'd0, 32'd1, $urandom);
		send_instr(MODE_OPR, 4'd0, 32'(OPR_ADD), $urandom);  // wraps to min
		send_instr(MODE_LIT, 4'd0, 32'hffff_ffff, $urandom);
		send_instr(MODE_OPR, 4'd0, 32'(OPR_DIV), $urandom);  // min / -1
		send_instr(MODE_LIT, 4'd0, 32'd0, $urandom);
		send_instr(MODE_OPR, 4'd0, 32'(OPR_MOD), $urandom);  // by zero
		send_instr(MODE_LIT, 4'd0, -32'sd7, $urandom);
		send_instr(MODE_OPR, 4'd0, 32'(OPR_ODD), $urandom);
		send_instr(MODE_OUT, 4'd0, 32'd0, $urandom);
		send_instr(MODE_OUT, 4'd0, 32'd0, $urandom);
	endtask

	// underflow, overflow, bad links, unknown codes
	task automatic test_range();
		send_instr(MODE_OUT, 4'd0, 32'd0, $urandom);     // empty stack
		send_instr(MODE_OPR, 4'd0, 32'(OPR_SUB), $urandom);
		send_instr(MODE_INC, 4'd0, STACK_DEPTH - 1, $urandom);
		send_instr(MODE_IN, 4'd0, 32'd0, 32'h8000_0000);
		send_instr(MODE_LIT, 4'd0, 32'd5, $urandom);     // overflow
		send_instr(MODE_INC, 4'd0, -STACK_DEPTH, $urandom);
		send_instr(MODE_LOD, 4'd15, 32'd0, $urandom);
		send_instr(4'd0, 4'd0, 32'd0, $urandom);
		send_instr(4'd15, 4'd15, 32'hffff_ffff, $urandom);
		send_instr(MODE_OPR, 4'd0, 32'd14, $urandom);
	endtask

	// call frame, locals through static link, return, jumps
	task automatic test_calls();
		send_instr(MODE_CAL, 4'd0, 32'hffff_f005, $urandom);
		send_instr(MODE_INC, 4'd0, 32'd4, $urandom);
		send_instr(MODE_LIT, 4'd0, 32'd42, $urandom);
		send_instr(MODE_STO, 4'd1, 32'd3, $urandom);
		send_instr(MODE_LOD, 4'd0, 32'd3, $urandom);
		send_instr(MODE_JPC, 4'd0, 32'd77, $urandom);
		send_instr(MODE_JMP, 4'd0, 32'hffff_ffff, $urandom);
		send_instr(MODE_OPR, 4'd0, 32'(OPR_RET), $urandom);
	endtask

	// random programs driven from the shadow state
	task automatic test_random();
		int k;
		logic [3:0] md, lv;
		logic [31:0] m, iv;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			idle_on = !(n >= 400 && n < 700);   // quiet stretch on both sides
			k  = $urandom_range(0, 99);
			lv = 4'd0;
			iv = $urandom;
			m  = 32'd0;
			if (mach_sp > STACK_DEPTH - 40) begin
				md = MODE_INC;
				m  = -($urandom_range(20, 200));
			end else if (k < 15) begin
				md = MODE_LIT;
				case ($urandom_range(0, 3))
					0: m = $urandom;
					1: m = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
					default: m = $signed($urandom_range(0, 8)) - 4;
				endcase
			end else if (k < 40) begin
				md = MODE_OPR;
				m  = $urandom_range(1, 13);
			end else if (k < 50) begin
				md = MODE_LOD;
				lv = 4'($urandom_range(0, 2));
				m  = $urandom_range(0, 6);
			end else if (k < 58) begin
				md = MODE_STO;
				lv = 4'($urandom_range(0, 2));
				m  = $urandom_range(3, 6);
			end else if (k < 64) begin
				md = MODE_CAL;
				lv = 4'($urandom_range(0, 1));
				m  = $urandom;
			end else if (k < 70) begin
				md = (mach_bp != 0) ? MODE_OPR : MODE_INC;
				m  = (mach_bp != 0) ? 32'(OPR_RET) : 32'd3;
			end else if (k < 75) begin
				md = MODE_INC;
				m  = $signed($urandom_range(0, 6)) - 2;
			end else if (k < 80) begin
				md = $urandom_range(0, 1) ? MODE_JMP : MODE_JPC;
				m  = $urandom;
			end else if (k < 86) begin
				md = $urandom_range(0, 1) ? MODE_OUT : MODE_IN;
			end else begin
				// noise over the whole field space
				md = 4'($urandom_range(0, 15));
				lv = 4'($urandom_range(0, 15));
				m  = $urandom;
				if ($urandom_range(0, 1)) m = m & 32'hf;
			end
			// a return from the outermost frame is saved for the end
			if (md == MODE_OPR && m == OPR_RET && mach_bp == 0) m = 32'(OPR_NEG);
			send_instr(md, lv, m, iv);
		end
		idle_on = 1'b1;
	endtask

	// unwind to the outermost frame, halt, then show that nothing moves
	task automatic test_halt();
		for (int i = 0; i < 40 && mach_bp != 0; i++)
			send_instr(MODE_OPR, 4'd0, 32'(OPR_RET), $urandom);
		if (mach_bp == 0)
			send_instr(MODE_OPR, 4'd0, 32'(OPR_RET), $urandom);
		send_instr(MODE_LIT, 4'd0, 32'd9, $urandom);
		send_instr(MODE_JMP, 4'd0, 32'd100, $urandom);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = '0;
		level     = '0;
		operand   = '0;
		in_value  = '0;
		idle_on   = 1'b1;
		mismatch_cnt  = 0;
		beats_sent    = 0;
		beats_checked = 0;
		out_beats     = 0;
		fault_beats   = 0;
		cycle_cnt     = 0;
		for (int i = 0; i < STACK_DEPTH; i++) mach_stack[i] = '0;
		mach_pc   = '0;
		mach_bp   = 0;
		mach_sp   = -1;
		mach_halt = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_arith();
		test_range();
		test_calls();
		test_random();
		test_halt();

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("sent %0d instructions, checked %0d results (%0d OUT beats, %0d faults)",
			beats_sent, beats_checked, out_beats, fault_beats);
		$display("machine halted=%0b, %0d mismatches", mach_halt, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
